FILE: rtl/sds_pkg.sv
package sds_pkg;

	localparam int unsigned WORD_BITS  = 32;
	localparam int unsigned FRAC_BITS  = 16;
	localparam int unsigned MAG_W      = WORD_BITS - 1;
	// dividend is pixel_scale with the fraction appended
	localparam int unsigned NUM_BITS   = MAG_W + FRAC_BITS;
	// depth floor is above 2^(FRAC_BITS-4), so the quotient stays below 2^(WORD_BITS+3)
	localparam int unsigned Q_BITS     = WORD_BITS + 3;
	localparam int unsigned SUM_BITS   = 2 * WORD_BITS + 2;
	localparam int unsigned DEPTH_BITS = SUM_BITS - FRAC_BITS + 1;
	localparam int unsigned LO_BITS    = Q_BITS / 2;
	localparam int unsigned HI_BITS    = Q_BITS - LO_BITS;
	localparam int unsigned PROD_BITS  = Q_BITS + MAG_W;
	localparam int unsigned SAT_BIT    = FRAC_BITS + WORD_BITS - 2;
	localparam int unsigned CFG_IDX_BITS = 3;

	localparam logic [DEPTH_BITS-1:0] DEPTH_FLOOR = DEPTH_BITS'((2 ** FRAC_BITS + 5) / 10);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_ROW_X,
		CFG_ROW_Y,
		CFG_ROW_Z,
		CFG_DEPTH_OFFSET,
		CFG_PIXEL_SCALE
	} cfg_reg_t;

	typedef struct packed {
		logic [NUM_BITS-1:0]   rem;
		logic [Q_BITS-1:0]     quot;
		logic [DEPTH_BITS-1:0] mag;
		logic [MAG_W-1:0]      rad;
	} div_item_t;

endpackage

FILE: rtl/sds_in_if.sv
interface sds_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sds_pkg::WORD_BITS-1:0] center_x;
	logic signed [sds_pkg::WORD_BITS-1:0] center_y;
	logic signed [sds_pkg::WORD_BITS-1:0] center_z;
	logic [sds_pkg::MAG_W-1:0]            radius;

	modport source (output valid, output center_x, output center_y, output center_z,
		output radius, input ready);
	modport sink (input valid, input center_x, input center_y, input center_z,
		input radius, output ready);
endinterface

FILE: rtl/sds_out_if.sv
interface sds_out_if;
	logic                      valid;
	logic                      ready;
	logic [sds_pkg::MAG_W-1:0] diameter;
	logic                      saturated;

	modport source (output valid, output diameter, output saturated, input ready);
	modport sink (input valid, input diameter, input saturated, output ready);
endinterface

FILE: rtl/sds_depth.sv
module sds_depth (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic signed [sds_pkg::WORD_BITS-1:0]  row_x,
	input  logic signed [sds_pkg::WORD_BITS-1:0]  row_y,
	input  logic signed [sds_pkg::WORD_BITS-1:0]  row_z,
	input  logic signed [sds_pkg::WORD_BITS-1:0]  depth_offset,
	sds_in_if.sink                                sphere,
	output logic                                  dn_valid,
	input  logic                                  dn_ready,
	output logic [sds_pkg::DEPTH_BITS-1:0]        mag,
	output logic [sds_pkg::MAG_W-1:0]             rad
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	logic signed [2*sds_pkg::WORD_BITS-1:0] px_s1, py_s1, pz_s1;
	logic [sds_pkg::MAG_W-1:0]              rad_s1, rad_s2, rad_s3, rad_s4;
	logic signed [sds_pkg::SUM_BITS-1:0]    sum_s2;
	logic signed [sds_pkg::DEPTH_BITS-1:0]  depth_s3;
	logic [sds_pkg::DEPTH_BITS-1:0]         mag_s4;
	logic [sds_pkg::DEPTH_BITS-1:0]         depth_abs;
	logic [sds_pkg::DEPTH_BITS-1:0]         mag_next;

	assign en4 = !v_s4 || dn_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign sphere.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= sphere.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_comb begin
		depth_abs = depth_s3[sds_pkg::DEPTH_BITS-1] ? sds_pkg::DEPTH_BITS'(-depth_s3)
			: sds_pkg::DEPTH_BITS'(depth_s3);
		mag_next = (depth_abs <= sds_pkg::DEPTH_FLOOR) ? sds_pkg::DEPTH_FLOOR : depth_abs;
	end

	always_ff @(posedge clk) begin
		if (en1 && sphere.valid) begin
			px_s1  <= (2 * sds_pkg::WORD_BITS)'(row_x)
				* (2 * sds_pkg::WORD_BITS)'(sphere.center_x);
			py_s1  <= (2 * sds_pkg::WORD_BITS)'(row_y)
				* (2 * sds_pkg::WORD_BITS)'(sphere.center_y);
			pz_s1  <= (2 * sds_pkg::WORD_BITS)'(row_z)
				* (2 * sds_pkg::WORD_BITS)'(sphere.center_z);
			rad_s1 <= sphere.radius;
		end
		// exact sum of the three products, floored once
		if (en2 && v_s1) begin
			sum_s2 <= sds_pkg::SUM_BITS'(px_s1) + sds_pkg::SUM_BITS'(py_s1)
				+ sds_pkg::SUM_BITS'(pz_s1);
			rad_s2 <= rad_s1;
		end
		if (en3 && v_s2) begin
			depth_s3 <= sds_pkg::DEPTH_BITS'(sum_s2 >>> sds_pkg::FRAC_BITS)
				+ sds_pkg::DEPTH_BITS'(depth_offset);
			rad_s3   <= rad_s2;
		end
		if (en4 && v_s3) begin
			mag_s4 <= mag_next;
			rad_s4 <= rad_s3;
		end
	end

	assign dn_valid = v_s4;
	assign mag      = mag_s4;
	assign rad      = rad_s4;

	a_floor: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> mag_s4 >= sds_pkg::DEPTH_FLOOR)
		else $error("depth below floor reached the divider");

endmodule

FILE: rtl/sds_div_cell.sv
module sds_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               num_bit,
	input  logic               up_valid,
	output logic               up_ready,
	input  sds_pkg::div_item_t up,
	output logic               dn_valid,
	input  logic               dn_ready,
	output sds_pkg::div_item_t dn
);

	logic               valid_q;
	logic               en;
	sds_pkg::div_item_t item_q;
	sds_pkg::div_item_t item_next;
	logic [sds_pkg::NUM_BITS-1:0] shifted;
	logic [sds_pkg::NUM_BITS-1:0] diff;
	logic                         ge;

	assign en       = !valid_q || dn_ready;
	assign up_ready = en;

	// one restoring step: bring in the next dividend bit, subtract if it fits
	always_comb begin
		shifted = {up.rem[sds_pkg::NUM_BITS-2:0], num_bit};
		ge      = sds_pkg::DEPTH_BITS'(shifted) >= up.mag;
		diff    = shifted - up.mag[sds_pkg::NUM_BITS-1:0];
		item_next.rem  = ge ? diff : shifted;
		item_next.quot = {up.quot[sds_pkg::Q_BITS-2:0], ge};
		item_next.mag  = up.mag;
		item_next.rad  = up.rad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && up_valid) begin
			item_q <= item_next;
		end
	end

	assign dn_valid = valid_q;
	assign dn       = item_q;

	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> sds_pkg::DEPTH_BITS'(item_q.rem) < item_q.mag)
		else $error("partial remainder not below divisor");

endmodule

FILE: rtl/sds_scale.sv
module sds_scale (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       up_valid,
	output logic                       up_ready,
	input  logic [sds_pkg::Q_BITS-1:0] quot,
	input  logic [sds_pkg::MAG_W-1:0]  rad,
	sds_out_if.source                  screen
);

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	logic [sds_pkg::LO_BITS+sds_pkg::MAG_W-1:0] lo_s1;
	logic [sds_pkg::HI_BITS+sds_pkg::MAG_W-1:0] hi_s1;
	logic [sds_pkg::PROD_BITS-1:0]              prod_s2;
	logic [sds_pkg::MAG_W-1:0]                  diam_s3;
	logic                                       sat_s3;
	logic                                       sat_next;

	assign en3 = !v_s3 || screen.ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign up_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= up_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// anything at or above 2^SAT_BIT would not fit once doubled
	assign sat_next = |prod_s2[sds_pkg::PROD_BITS-1:sds_pkg::SAT_BIT];

	always_ff @(posedge clk) begin
		if (en1 && up_valid) begin
			lo_s1 <= (sds_pkg::LO_BITS + sds_pkg::MAG_W)'(quot[sds_pkg::LO_BITS-1:0])
				* (sds_pkg::LO_BITS + sds_pkg::MAG_W)'(rad);
			hi_s1 <= (sds_pkg::HI_BITS + sds_pkg::MAG_W)'(quot[sds_pkg::Q_BITS-1:sds_pkg::LO_BITS])
				* (sds_pkg::HI_BITS + sds_pkg::MAG_W)'(rad);
		end
		if (en2 && v_s1) begin
			prod_s2 <= (sds_pkg::PROD_BITS'(hi_s1) << sds_pkg::LO_BITS)
				+ sds_pkg::PROD_BITS'(lo_s1);
		end
		if (en3 && v_s2) begin
			sat_s3  <= sat_next;
			diam_s3 <= sat_next ? {sds_pkg::MAG_W{1'b1}}
				: {prod_s2[sds_pkg::SAT_BIT-1:sds_pkg::FRAC_BITS], 1'b0};
		end
	end

	assign screen.valid     = v_s3;
	assign screen.diameter  = diam_s3;
	assign screen.saturated = sat_s3;

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && sat_s3 |-> &diam_s3)
		else $error("saturated item without full-scale diameter");

	a_even: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !sat_s3 |-> !diam_s3[0])
		else $error("unsaturated diameter is odd");

endmodule

FILE: rtl/sphere_screen_diameter.sv
// Projected sphere size: each item (centre and radius, Q16.16) gives one result, the
// on-screen diameter in pixels with a saturation flag. One item is taken every cycle
// unless a full pipeline is held by the result side, and results come out in order after
// registered depth arithmetic (three 32x32 products, their sum, the offset, magnitude and
// floor), a chain of 35 divider cells that each settle one quotient bit of pixel_scale /
// depth, and a registered split radius multiply and clamp. Backpressure on the result side
// stalls only full stages, so empty slots in the chain keep filling. Registers may be written only
// when nothing is in flight; a write at index 5 to 7 is ignored.
module sphere_screen_diameter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [sds_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [sds_pkg::WORD_BITS-1:0]         cfg_data,
	sds_in_if.sink                                sphere,
	sds_out_if.source                             screen
);

	logic signed [sds_pkg::WORD_BITS-1:0] row_x_q, row_y_q, row_z_q, depth_offset_q;
	logic [sds_pkg::MAG_W-1:0]            pixel_scale_q;
	logic [sds_pkg::NUM_BITS-1:0]         numer;

	logic                           depth_valid;
	logic [sds_pkg::DEPTH_BITS-1:0] depth_mag;
	logic [sds_pkg::MAG_W-1:0]      depth_rad;

	sds_pkg::div_item_t chain       [sds_pkg::Q_BITS+1];
	logic               chain_valid [sds_pkg::Q_BITS+1];
	logic               chain_ready [sds_pkg::Q_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q        <= '0;
			row_y_q        <= '0;
			row_z_q        <= '0;
			depth_offset_q <= '0;
			pixel_scale_q  <= '0;
		end else if (cfg_we) begin
			case (sds_pkg::cfg_reg_t'(cfg_index))
				sds_pkg::CFG_ROW_X:        row_x_q        <= cfg_data;
				sds_pkg::CFG_ROW_Y:        row_y_q        <= cfg_data;
				sds_pkg::CFG_ROW_Z:        row_z_q        <= cfg_data;
				sds_pkg::CFG_DEPTH_OFFSET: depth_offset_q <= cfg_data;
				sds_pkg::CFG_PIXEL_SCALE:  pixel_scale_q  <= cfg_data[sds_pkg::MAG_W-1:0];
				default: ;
			endcase
		end
	end

	assign numer = {pixel_scale_q, {sds_pkg::FRAC_BITS{1'b0}}};

	sds_depth u_depth (
		.clk          (clk),
		.arst_n       (arst_n),
		.row_x        (row_x_q),
		.row_y        (row_y_q),
		.row_z        (row_z_q),
		.depth_offset (depth_offset_q),
		.sphere       (sphere),
		.dn_valid     (depth_valid),
		.dn_ready     (chain_ready[0]),
		.mag          (depth_mag),
		.rad          (depth_rad)
	);

	// dividend bits above the quotient range are always below the divisor
	always_comb begin
		chain[0].rem  = sds_pkg::NUM_BITS'(numer >> sds_pkg::Q_BITS);
		chain[0].quot = '0;
		chain[0].mag  = depth_mag;
		chain[0].rad  = depth_rad;
	end
	assign chain_valid[0] = depth_valid;

	for (genvar i = 0; i < sds_pkg::Q_BITS; i++) begin : g_div
		sds_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.num_bit  (numer[sds_pkg::Q_BITS-1-i]),
			.up_valid (chain_valid[i]),
			.up_ready (chain_ready[i]),
			.up       (chain[i]),
			.dn_valid (chain_valid[i+1]),
			.dn_ready (chain_ready[i+1]),
			.dn       (chain[i+1])
		);
	end

	sds_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (chain_valid[sds_pkg::Q_BITS]),
		.up_ready (chain_ready[sds_pkg::Q_BITS]),
		.quot     (chain[sds_pkg::Q_BITS].quot),
		.rad      (chain[sds_pkg::Q_BITS].rad),
		.screen   (screen)
	);

endmodule
